// ----- hw/rtl/mec_pkg.sv -----
package mec_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int C_W         = 31;
    localparam int XY_W        = 32;
    localparam int PROD_W      = 64;
    localparam int COUNT_W     = 16;
    localparam int COLOR_W     = 8;
    localparam int RGB_W       = 3 * COLOR_W;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 48;

    localparam int FIERY_W     = 6;
    localparam logic [FIERY_W-1:0] FIERY_LAST = FIERY_W'(50);
    localparam int PAL_IDX_W   = 8;
    localparam int BASE_COLORS_N = 16;

    localparam int QUOT_W      = 8;
    localparam int DIVIDEND_W  = COUNT_W + QUOT_W;
    localparam int DIVISOR_W   = COUNT_W + 1;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int BLUE_B_NUM  = 255;
    localparam int BLUE_RG_NUM = 153;

    // |z|^2 bound of 4 with both squares at 2*FRAC_BITS fraction bits.
    localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

    localparam logic [RGB_W-1:0] BASE_COLORS [BASE_COLORS_N] = '{
        24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
        24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
        24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
        24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
    };

    typedef logic [COLOR_W-1:0] ramp_t [2**FIERY_W];

    function automatic ramp_t fiery_red_table();
        ramp_t t;
        for (int i = 0; i < 2**FIERY_W; i++)
        begin
            t[i] = COLOR_W'((i * 255) / 50);
        end
        return t;
    endfunction

    function automatic ramp_t fiery_green_table();
        ramp_t t;
        for (int i = 0; i < 2**FIERY_W; i++)
        begin
            t[i] = COLOR_W'((i * 153) / 100);
        end
        return t;
    endfunction

    localparam ramp_t FIERY_RED   = fiery_red_table();
    localparam ramp_t FIERY_GREEN = fiery_green_table();

    typedef struct packed {
        logic                        start;
        logic signed [C_W-1:0]       c_real;
        logic signed [C_W-1:0]       c_imag;
        logic [COUNT_W-1:0]          iter_limit;
    } core_req_t;

    typedef struct packed {
        logic                        done;
        logic [COUNT_W-1:0]          count;
        logic [FIERY_W-1:0]          fiery_idx;
        logic [PAL_IDX_W-1:0]        pal_idx;
    } core_stat_t;

    typedef struct packed {
        logic                        start;
        logic [DIVIDEND_W-1:0]       dividend;
        logic [DIVISOR_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic [QUOT_W-1:0]           quotient;
    } div_stat_t;

endpackage

// ----- hw/rtl/mec_escape_core.sv -----
module mec_escape_core #(
    parameter int PALETTE_SIZE = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mec_pkg::core_req_t   req,
    output mec_pkg::core_stat_t  stat
);

    localparam int PAL_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [PAL_W-1:0] PAL_LAST = PAL_W'(PALETTE_SIZE - 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_UPD
    } core_state_t;

    core_state_t                            state_reg;
    logic signed [mec_pkg::XY_W-1:0]        x_reg;
    logic signed [mec_pkg::XY_W-1:0]        y_reg;
    logic signed [mec_pkg::C_W-1:0]         cr_reg;
    logic signed [mec_pkg::C_W-1:0]         ci_reg;
    logic [mec_pkg::PROD_W-1:0]             xx_reg;
    logic [mec_pkg::PROD_W-1:0]             yy_reg;
    logic signed [mec_pkg::PROD_W-1:0]      xy_reg;
    logic [mec_pkg::COUNT_W-1:0]            n_reg;
    logic [mec_pkg::FIERY_W-1:0]            k_reg;
    logic [PAL_W-1:0]                       p_reg;
    logic                                   done_reg;

    logic signed [mec_pkg::PROD_W-1:0]      prod_xx;
    logic signed [mec_pkg::PROD_W-1:0]      prod_yy;
    logic signed [mec_pkg::PROD_W-1:0]      prod_xy;
    logic [mec_pkg::PROD_W:0]               mag_sum;
    logic                                   keep_going;
    logic signed [mec_pkg::PROD_W-1:0]      diff;
    logic signed [mec_pkg::PROD_W-1:0]      nx_full;
    logic signed [mec_pkg::PROD_W-1:0]      ny_full;

    assign prod_xx = x_reg * x_reg;
    assign prod_yy = y_reg * y_reg;
    assign prod_xy = x_reg * y_reg;

    assign mag_sum    = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign keep_going = (n_reg < req.iter_limit) && (mag_sum <= mec_pkg::ESC_LIMIT);

    // Both squares are below 2^63, so the difference cannot overflow.
    assign diff    = $signed(xx_reg) - $signed(yy_reg);
    assign nx_full = (diff >>> mec_pkg::FRAC_BITS) + mec_pkg::PROD_W'(cr_reg);
    assign ny_full = (xy_reg >>> (mec_pkg::FRAC_BITS - 1)) + mec_pkg::PROD_W'(ci_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            cr_reg    <= '0;
            ci_reg    <= '0;
            xx_reg    <= '0;
            yy_reg    <= '0;
            xy_reg    <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            p_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        cr_reg    <= req.c_real;
                        ci_reg    <= req.c_imag;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        n_reg     <= '0;
                        k_reg     <= '0;
                        p_reg     <= '0;
                        state_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    xx_reg    <= prod_xx;
                    yy_reg    <= prod_yy;
                    xy_reg    <= prod_xy;
                    state_reg <= C_UPD;
                end
                C_UPD:
                begin
                    if (keep_going)
                    begin
                        x_reg     <= nx_full[mec_pkg::XY_W-1:0];
                        y_reg     <= ny_full[mec_pkg::XY_W-1:0];
                        n_reg     <= n_reg + mec_pkg::COUNT_W'(1);
                        k_reg     <= (k_reg == mec_pkg::FIERY_LAST) ? '0
                                     : k_reg + mec_pkg::FIERY_W'(1);
                        p_reg     <= (p_reg == PAL_LAST) ? '0 : p_reg + PAL_W'(1);
                        state_reg <= C_MUL;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.done      = done_reg;
    assign stat.count     = n_reg;
    assign stat.fiery_idx = k_reg;
    assign stat.pal_idx   = mec_pkg::PAL_IDX_W'(p_reg);

endmodule

// ----- hw/rtl/mec_divider.sv -----
module mec_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  mec_pkg::div_req_t   req,
    output mec_pkg::div_stat_t  stat
);

    logic [mec_pkg::DIVISOR_W-1:0]   rem_reg;
    logic [mec_pkg::DIVISOR_W-1:0]   divisor_reg;
    logic [mec_pkg::QUOT_W-1:0]      lo_reg;
    logic [mec_pkg::QUOT_W-1:0]      q_reg;
    logic [mec_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                            done_reg;

    logic [mec_pkg::DIVISOR_W:0]     trial;
    logic [mec_pkg::DIVISOR_W:0]     trial_diff;
    logic                            fits;

    assign trial      = {rem_reg, lo_reg[mec_pkg::QUOT_W-1]};
    assign fits       = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};

    // Restoring division, one quotient bit per cycle, most significant first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            divisor_reg <= '0;
            lo_reg      <= '0;
            q_reg       <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg     <= mec_pkg::DIVISOR_W'(
                                   req.dividend[mec_pkg::DIVIDEND_W-1:mec_pkg::QUOT_W]);
                lo_reg      <= req.dividend[mec_pkg::QUOT_W-1:0];
                divisor_reg <= req.divisor;
                q_reg       <= '0;
                cnt_reg     <= mec_pkg::DIV_CNT_W'(mec_pkg::DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                rem_reg <= fits ? trial_diff[mec_pkg::DIVISOR_W-1:0]
                                : trial[mec_pkg::DIVISOR_W-1:0];
                q_reg   <= {q_reg[mec_pkg::QUOT_W-2:0], fits};
                lo_reg  <= {lo_reg[mec_pkg::QUOT_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - mec_pkg::DIV_CNT_W'(1);
                if (cnt_reg == mec_pkg::DIV_CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = q_reg;

endmodule

// ----- hw/rtl/mandelbrot_escape_colorer.sv -----
// Escape-time evaluator for one complex point per item, with pixel coloring.
// The input stream (s_tvalid, s_tready, s_tdata) carries c_real and c_imag in
// signed Q3.28. The output stream (m_tvalid, m_tready, m_tdata) carries the
// iteration count, the inside flag and an RGB color. An item moves on a rising
// clock edge where tvalid and tready are both high.
// The configuration port (cfg_we, cfg_index, cfg_data) sets max_iterations
// (index 0) and color_mode (index 1); write it only while the block is idle.
// One shared set of three 32x32 multipliers performs z = z^2 + c, and each
// iteration multiplies first and then tests and updates. Blue mode adds two
// 8-step divisions after the iteration. One point is in work at a time;
// s_tready is high only while no point is being evaluated.
// The result sits in an output register, so a new item is accepted while an
// earlier result waits for m_tready; a finished point then waits until the
// register is free. Reset empties the pipeline and sets max_iterations to
// 256 and color_mode to binary.
module mandelbrot_escape_colorer #(
    parameter int PALETTE_SIZE = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // c_real [30:0], c_imag [61:31], zero [63:62]
    input  logic [mec_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // iteration_count [15:0], inside_res [16], red [24:17], green [32:25],
    // blue [40:33], zero [47:41]
    output logic [mec_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_we,
    input  logic [mec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mec_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [mec_pkg::CFG_INDEX_W-1:0] REG_ITER_LIMIT = 1'd0;
    localparam logic [mec_pkg::CFG_INDEX_W-1:0] REG_COLOR_MODE = 1'd1;

    localparam logic [mec_pkg::MODE_W-1:0] MODE_BINARY = 2'd0;
    localparam logic [mec_pkg::MODE_W-1:0] MODE_FIERY  = 2'd1;
    localparam logic [mec_pkg::MODE_W-1:0] MODE_BLUE   = 2'd2;
    localparam logic [mec_pkg::MODE_W-1:0] MODE_WAVY   = 2'd3;

    localparam logic [mec_pkg::COLOR_W-1:0] FULL = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_DIV_B,
        ST_DIV_R,
        ST_WRITE
    } state_t;

    state_t                               state_reg;
    logic                                 m_tvalid_reg;
    logic [mec_pkg::M_DATA_W-1:0]         m_tdata_reg;
    logic [mec_pkg::QUOT_W-1:0]           blue_q_reg;
    logic [mec_pkg::QUOT_W-1:0]           red_q_reg;
    logic [mec_pkg::COUNT_W-1:0]          iter_limit_reg;
    logic [mec_pkg::MODE_W-1:0]           mode_reg;

    mec_pkg::core_req_t                   core_req;
    mec_pkg::core_stat_t                  core_stat;
    mec_pkg::div_req_t                    div_req;
    mec_pkg::div_stat_t                   div_stat;

    logic                                 go_blue;
    logic                                 in_set;
    logic [mec_pkg::COUNT_W-1:0]          remaining;
    logic [mec_pkg::DIVIDEND_W-1:0]       dividend_b;
    logic [mec_pkg::DIVIDEND_W-1:0]       dividend_r;
    logic [mec_pkg::RGB_W-1:0]            pal_color;
    logic [mec_pkg::COLOR_W-1:0]          red;
    logic [mec_pkg::COLOR_W-1:0]          green;
    logic [mec_pkg::COLOR_W-1:0]          blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_limit_reg <= mec_pkg::COUNT_W'(256);
            mode_reg       <= MODE_BINARY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ITER_LIMIT: iter_limit_reg <= cfg_data;
                REG_COLOR_MODE: mode_reg       <= cfg_data[mec_pkg::MODE_W-1:0];
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    assign core_req.start      = s_tvalid && s_tready;
    assign core_req.c_real     = $signed(s_tdata[mec_pkg::C_W-1:0]);
    assign core_req.c_imag     = $signed(s_tdata[2*mec_pkg::C_W-1:mec_pkg::C_W]);
    assign core_req.iter_limit = iter_limit_reg;

    mec_escape_core #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (core_req),
        .stat  (core_stat)
    );

    assign go_blue    = (mode_reg == MODE_BLUE) && (iter_limit_reg != '0);
    assign remaining  = iter_limit_reg - core_stat.count;
    assign dividend_b = {remaining, {mec_pkg::QUOT_W{1'b0}}}
                        - mec_pkg::DIVIDEND_W'(remaining);
    assign dividend_r = mec_pkg::DIVIDEND_W'(remaining)
                        * mec_pkg::DIVIDEND_W'(mec_pkg::BLUE_RG_NUM);

    assign div_req.start    = ((state_reg == ST_ITER) && core_stat.done && go_blue)
                              || ((state_reg == ST_DIV_B) && div_stat.done);
    assign div_req.dividend = (state_reg == ST_DIV_B) ? dividend_r : dividend_b;
    assign div_req.divisor  = (state_reg == ST_DIV_B) ? {iter_limit_reg, 1'b0}
                                                      : {1'b0, iter_limit_reg};

    mec_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    assign in_set    = (core_stat.count == iter_limit_reg);
    assign pal_color = mec_pkg::BASE_COLORS[core_stat.pal_idx[3:0]];

    always_comb
    begin
        red   = '0;
        green = '0;
        blue  = '0;
        unique case (mode_reg)
            MODE_BINARY:
            begin
                if (!in_set)
                begin
                    red   = FULL;
                    green = FULL;
                    blue  = FULL;
                end
            end
            MODE_FIERY:
            begin
                if (!in_set)
                begin
                    red   = mec_pkg::FIERY_RED[core_stat.fiery_idx];
                    green = mec_pkg::FIERY_GREEN[core_stat.fiery_idx];
                end
            end
            MODE_BLUE:
            begin
                if (iter_limit_reg != '0)
                begin
                    red   = red_q_reg;
                    green = red_q_reg;
                    blue  = blue_q_reg;
                end
            end
            MODE_WAVY:
            begin
                if (!in_set)
                begin
                    red   = pal_color[23:16];
                    green = pal_color[15:8];
                    blue  = pal_color[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            blue_q_reg   <= '0;
            red_q_reg    <= '0;
        end
        else
        begin
            if (m_tready && (state_reg != ST_WRITE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_ITER;
                    end
                end
                ST_ITER:
                begin
                    if (core_stat.done)
                    begin
                        state_reg <= go_blue ? ST_DIV_B : ST_WRITE;
                    end
                end
                ST_DIV_B:
                begin
                    if (div_stat.done)
                    begin
                        blue_q_reg <= div_stat.quotient;
                        state_reg  <= ST_DIV_R;
                    end
                end
                ST_DIV_R:
                begin
                    if (div_stat.done)
                    begin
                        red_q_reg <= div_stat.quotient;
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {7'b0, blue, green, red, in_set, core_stat.count};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another point is in work");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[mec_pkg::COUNT_W-1:0] <= iter_limit_reg))
        else $error("iteration count beyond the limit");

    a_inside_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[mec_pkg::COUNT_W]
                      == (m_tdata[mec_pkg::COUNT_W-1:0] == iter_limit_reg)))
        else $error("inside flag disagrees with the count");

    a_core_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> (state_reg == ST_ITER))
        else $error("iteration finished outside the iterate state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ((state_reg == ST_DIV_B) || (state_reg == ST_DIV_R)))
        else $error("division finished outside a divide state");

endmodule
